// ===== rtl/luma_color_normalizer_defines.svh =====
// Assertion macros shared by the luma color normalizer RTL.
`ifndef LUMA_COLOR_NORMALIZER_DEFINES_SVH
`define LUMA_COLOR_NORMALIZER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LCN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("luma_color_normalizer: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LCN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("luma_color_normalizer: next-cycle check failed");

`endif

// ===== rtl/lcn_pkg.sv =====
// Shared constants for the luma color normalizer.
`default_nettype none
package lcn_pkg;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int CHAN_W = 8;
  localparam int NUM_CH = 3;
  localparam int CH_RED = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE = 2;
  localparam logic [CHAN_W-1:0] TARGET_RESET = 8'd100;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
  // BT.709 weights in units of 1/10000.
  localparam longint KR_E4 = 2126;
  localparam longint KB_E4 = 722;
endpackage
`default_nettype wire

// ===== rtl/luma_color_normalizer.sv =====
// Top level of the luma color normalizer: luma, per-channel scale and saturation.
`default_nettype none
`include "luma_color_normalizer_defines.svh"

// Rescales each RGB pixel so that its BT.709 luma moves to target_luma, giving
// floor(c * target * 2^F / Ysum) per channel, saturated at 255; a black pixel gives
// all zeros. One pixel is taken every clock and busy stays low. Thirteen register
// stages sit between input and output: two form the luma and the numerators, one
// loads the divider, nine run a restoring divider that settles the saturation test
// and then one quotient bit per stage, and one registers the outputs. A result is on
// the out_ ports with out_valid for one cycle. The receiver cannot stall, so a
// result must be taken in the cycle that out_valid is high.
module luma_color_normalizer #(
  parameter int COEF_FRAC_BITS = lcn_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [lcn_pkg::CHAN_W-1:0] cfg_wdata,
  input  wire                       start,
  output logic                      busy,
  input  wire [lcn_pkg::CHAN_W-1:0] in_red_in,
  input  wire [lcn_pkg::CHAN_W-1:0] in_green_in,
  input  wire [lcn_pkg::CHAN_W-1:0] in_blue_in,
  output logic                      out_valid,
  output logic [lcn_pkg::CHAN_W-1:0] out_red_out,
  output logic [lcn_pkg::CHAN_W-1:0] out_green_out,
  output logic [lcn_pkg::CHAN_W-1:0] out_blue_out
);
  import lcn_pkg::*;

  localparam int KW = COEF_FRAC_BITS;
  localparam int YW = COEF_FRAC_BITS + CHAN_W;
  localparam int CTW = 2 * CHAN_W;
  localparam int NW = CTW + COEF_FRAC_BITS;
  localparam int QB = CHAN_W;
  localparam int DS = QB + 1;
  localparam longint ONE = longint'(1) << COEF_FRAC_BITS;
  localparam longint KR = ((KR_E4 << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint KB = ((KB_E4 << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint KG = ONE - KR - KB;
  localparam logic [KW-1:0] KR_C = KW'(KR);
  localparam logic [KW-1:0] KG_C = KW'(KG);
  localparam logic [KW-1:0] KB_C = KW'(KB);

  logic [CHAN_W-1:0] target_r;

  // Stage 1: weighted channels and c * target.
  logic              p1_vld_r;
  logic              p1_zero_r;
  logic [YW-1:0]     p1_prod_r [NUM_CH];
  logic [CTW-1:0]    p1_ct_r [NUM_CH];
  // Stage 2: luma sum and numerators.
  logic              p2_vld_r;
  logic              p2_zero_r;
  logic [YW-1:0]     p2_y_r;
  logic [CTW-1:0]    p2_ct_r [NUM_CH];

  // Divider stages.
  logic              d_vld_r  [DS+1];
  logic              d_zero_r [DS+1];
  logic [YW-1:0]     d_y_r    [DS+1];
  logic [NW-1:0]     d_rem_r  [DS+1][NUM_CH];
  logic [QB-1:0]     d_quo_r  [DS+1][NUM_CH];
  logic              d_sat_r  [DS+1][NUM_CH];
  logic [NW-1:0]     d_rem_nxt [DS+1][NUM_CH];
  logic [QB-1:0]     d_quo_nxt [DS+1][NUM_CH];
  logic              d_sat_nxt [DS+1][NUM_CH];

  logic [CHAN_W-1:0] pix [NUM_CH];
  logic [KW-1:0]     coef [NUM_CH];
  logic [CHAN_W-1:0] res_nxt [NUM_CH];

  assign busy = 1'b0;
  assign pix[CH_RED]    = in_red_in;
  assign pix[CH_GREEN]  = in_green_in;
  assign pix[CH_BLUE]   = in_blue_in;
  assign coef[CH_RED]   = KR_C;
  assign coef[CH_GREEN] = KG_C;
  assign coef[CH_BLUE]  = KB_C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= start && !busy;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_zero_r <= (in_red_in == '0) && (in_green_in == '0) && (in_blue_in == '0);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      p1_prod_r[ch] <= YW'(pix[ch]) * YW'(coef[ch]);
      p1_ct_r[ch]   <= CTW'(pix[ch]) * CTW'(target_r);
    end
    p2_zero_r <= p1_zero_r;
    p2_y_r    <= p1_prod_r[CH_RED] + p1_prod_r[CH_GREEN] + p1_prod_r[CH_BLUE];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      p2_ct_r[ch] <= p1_ct_r[ch];
    end
  end

  // Stage 0 of the divider tests for a quotient above 255; each later stage
  // settles one quotient bit, most significant first.
  always_comb begin
    logic [NW-1:0] dsh;
    dsh = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      d_rem_nxt[0][ch] = {p2_ct_r[ch], {COEF_FRAC_BITS{1'b0}}};
      d_quo_nxt[0][ch] = '0;
      d_sat_nxt[0][ch] = 1'b0;
    end
    for (int st = 0; st < DS; st++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        d_rem_nxt[st+1][ch] = d_rem_r[st][ch];
        d_quo_nxt[st+1][ch] = d_quo_r[st][ch];
        d_sat_nxt[st+1][ch] = d_sat_r[st][ch];
        if (st == 0) begin
          dsh = NW'(d_y_r[st]) << QB;
          d_sat_nxt[st+1][ch] = d_rem_r[st][ch] >= dsh;
        end else begin
          dsh = NW'(d_y_r[st]) << (QB - st);
          if (d_rem_r[st][ch] >= dsh) begin
            d_rem_nxt[st+1][ch] = d_rem_r[st][ch] - dsh;
            d_quo_nxt[st+1][ch][QB-st] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int st = 0; st <= DS; st++) begin
        d_vld_r[st] <= 1'b0;
      end
    end else begin
      d_vld_r[0] <= p2_vld_r;
      for (int st = 0; st < DS; st++) begin
        d_vld_r[st+1] <= d_vld_r[st];
      end
    end
  end

  always_ff @(posedge clk) begin
    d_zero_r[0] <= p2_zero_r;
    d_y_r[0]    <= p2_y_r;
    for (int st = 0; st < DS; st++) begin
      d_zero_r[st+1] <= d_zero_r[st];
      d_y_r[st+1]    <= d_y_r[st];
    end
    for (int st = 0; st <= DS; st++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        d_rem_r[st][ch] <= d_rem_nxt[st][ch];
        d_quo_r[st][ch] <= d_quo_nxt[st][ch];
        d_sat_r[st][ch] <= d_sat_nxt[st][ch];
      end
    end
  end

  // A black pixel has zero luma and gives zero on every channel.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (d_zero_r[DS]) begin
        res_nxt[ch] = '0;
      end else if (d_sat_r[DS][ch]) begin
        res_nxt[ch] = CHAN_MAX;
      end else begin
        res_nxt[ch] = d_quo_r[DS][ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_vld_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    out_red_out   <= res_nxt[CH_RED];
    out_green_out <= res_nxt[CH_GREEN];
    out_blue_out  <= res_nxt[CH_BLUE];
  end

  `LCN_ASSERT_NOW(a_latency, start && !busy, ##(DS+4) out_valid)
  `LCN_ASSERT_NOW(a_no_spurious, out_valid, $past(start, DS+4))
  `LCN_ASSERT_NEXT(a_black_zero, d_vld_r[DS] && d_zero_r[DS],
                   out_red_out == '0 && out_green_out == '0 && out_blue_out == '0)
  `LCN_ASSERT_NEXT(a_red_sat, d_vld_r[DS] && !d_zero_r[DS] && d_sat_r[DS][CH_RED],
                   out_red_out == CHAN_MAX)
endmodule
`default_nettype wire
